@@ sv/quadtree_bitmap_encoder_top_assert.svh @@
// assertion macros for the quadtree bitmap encoder checker
// no dependencies; included by the checker file
`ifndef QUADTREE_BITMAP_ENCODER_TOP_ASSERT_SVH
`define QUADTREE_BITMAP_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define QBE_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, also checked during reset
`define QBE_ASSERT_NXT(lbl, clk, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

@@ sv/qbe_pkg.sv @@
// shared types and constants for the quadtree bitmap encoder
// no dependencies
package qbe_pkg;

  localparam int MAX_DIM_DEF     = 256;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int PSUM_W          = 17;
  localparam int CFG_W           = 9;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] SYM_ZERO = 2'd0;
  localparam logic [1:0] SYM_ONE  = 2'd1;
  localparam logic [1:0] SYM_DIV  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_POP,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_Q4,
    ST_EVAL,
    ST_PUSH,
    ST_OUT
  } qbe_state_t;

endpackage

@@ sv/quadtree_bitmap_encoder_top.sv @@
// quadtree bitmap encoder top: prefix-sum and region stack memories, sequencer; needs qbe_pkg
// load transfer: read of the entry above, then write back of the new prefix sum
// step transfer: a pop, the four reads through the single prefix-sum read port and an evaluation;
//   a split region then adds two or four pushes, one push a cycle on the stack write port
// a result sits in an output register; the next input is taken once the sequencer is idle
// reset (synchronous, rst_n low): rows = cols = 1, load position 0, stack empty, no clearing pass
module quadtree_bitmap_encoder_top #(
  parameter int MAX_DIM     = qbe_pkg::MAX_DIM_DEF,
  parameter int STACK_DEPTH = qbe_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [0] pixel
  input  logic [0:0]                     in_tuser,   // [0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [1:0] symbol
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [qbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qbe_pkg::CFG_W-1:0]      cfg_wdata
);
  import qbe_pkg::*;

  localparam int AW     = $clog2(MAX_DIM);
  localparam int DW     = AW + 1;
  localparam int PAW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int AREA_W = 2 * DW;
  localparam int CMP_W  = AREA_W + PSUM_W;

  typedef struct packed {
    logic [AW-1:0] r0;
    logic [AW-1:0] r1;
    logic [AW-1:0] c0;
    logic [AW-1:0] c1;
  } region_t;

  // state register and control
  qbe_state_t state_r, state_nxt;
  logic [CFG_W-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [AW-1:0]    lrow_r, lrow_nxt, lcol_r, lcol_nxt;
  logic [DW-1:0]    rsum_r, rsum_nxt;
  logic             frame_r, frame_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload / working registers
  logic [AW-1:0]     ld_row_r, ld_row_nxt, ld_col_r, ld_col_nxt;
  logic [DW-1:0]     ld_sum_r, ld_sum_nxt;
  region_t           reg_r, reg_nxt;
  logic [PSUM_W-1:0] acc_r, acc_nxt;
  logic [AREA_W-1:0] area_r, area_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              split_r_r, split_r_nxt, split_c_r, split_c_nxt;
  logic [1:0]        sym_r, sym_nxt;
  logic [1:0]        out_sym_r, out_sym_nxt;
  logic              out_last_r, out_last_nxt;

  // prefix-sum memory
  logic [PSUM_W-1:0] psum_mem [MAX_DIM*MAX_DIM];
  logic              ps_we;
  logic [PAW-1:0]    ps_waddr, ps_raddr;
  logic [PSUM_W-1:0] ps_wdata, ps_q;

  // region stack memory
  region_t           stk_mem [STACK_DEPTH];
  logic              stk_we;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  region_t           stk_wdata, stk_q;

  // effective frame size
  logic [DW-1:0] nr, nc;
  logic [AW-1:0] r0m1, c0m1, mr, mc;
  logic          rhi, chi;
  region_t       push_reg;
  logic [AW-1:0] lr, lc;
  logic [DW-1:0] rs;

  function automatic logic [PAW-1:0] paddr(input logic [AW-1:0] r, input logic [AW-1:0] c);
    paddr = PAW'(r) * PAW'(MAX_DIM) + PAW'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (ps_we) begin
      psum_mem[ps_waddr] <= ps_wdata;
    end
    ps_q <= psum_mem[ps_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // zero acts as one, above the limit acts as the limit
  always_comb begin
    if (rows_r == '0) nr = DW'(1);
    else if (int'(rows_r) > MAX_DIM) nr = DW'(MAX_DIM);
    else nr = DW'(rows_r);
    if (cols_r == '0) nc = DW'(1);
    else if (int'(cols_r) > MAX_DIM) nc = DW'(MAX_DIM);
    else nc = DW'(cols_r);
  end

  // region helpers: index minus one clamped to zero, floor midpoints, push selection
  always_comb begin
    r0m1     = (reg_r.r0 == '0) ? '0 : reg_r.r0 - AW'(1);
    c0m1     = (reg_r.c0 == '0) ? '0 : reg_r.c0 - AW'(1);
    mr       = AW'((DW'(reg_r.r0) + DW'(reg_r.r1)) >> 1);
    mc       = AW'((DW'(reg_r.c0) + DW'(reg_r.c1)) >> 1);
    rhi      = split_c_r ? !idx_r[1] : !idx_r[0];
    chi      = !idx_r[0];
    push_reg = reg_r;
    if (split_r_r) begin
      push_reg.r0 = rhi ? mr + AW'(1) : reg_r.r0;
      push_reg.r1 = rhi ? reg_r.r1 : mr;
    end
    if (split_c_r) begin
      push_reg.c0 = chi ? mc + AW'(1) : reg_r.c0;
      push_reg.c1 = chi ? reg_r.c1 : mc;
    end
  end

  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_sym_r};
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= CFG_W'(1);
      cols_r      <= CFG_W'(1);
      lrow_r      <= '0;
      lcol_r      <= '0;
      rsum_r      <= '0;
      frame_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      lrow_r      <= lrow_nxt;
      lcol_r      <= lcol_nxt;
      rsum_r      <= rsum_nxt;
      frame_r     <= frame_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_row_r   <= ld_row_nxt;
    ld_col_r   <= ld_col_nxt;
    ld_sum_r   <= ld_sum_nxt;
    reg_r      <= reg_nxt;
    acc_r      <= acc_nxt;
    area_r     <= area_nxt;
    idx_r      <= idx_nxt;
    split_r_r  <= split_r_nxt;
    split_c_r  <= split_c_nxt;
    sym_r      <= sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    lrow_nxt      = lrow_r;
    lcol_nxt      = lcol_r;
    rsum_nxt      = rsum_r;
    frame_nxt     = frame_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    ld_sum_nxt    = ld_sum_r;
    reg_nxt       = reg_r;
    acc_nxt       = acc_r;
    area_nxt      = area_r;
    idx_nxt       = idx_r;
    split_r_nxt   = split_r_r;
    split_c_nxt   = split_c_r;
    sym_nxt       = sym_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    ps_we         = 1'b0;
    ps_waddr      = '0;
    ps_wdata      = '0;
    ps_raddr      = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = reg_r;
    stk_raddr     = '0;
    lr            = lrow_r;
    lc            = lcol_r;
    rs            = rsum_r;

    // output register drains on its transfer
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser[0] == KIND_LOAD) begin
            // pixel after a complete frame starts a new one
            if (frame_r || DW'(lrow_r) >= nr || DW'(lcol_r) >= nc) begin
              lr        = '0;
              lc        = '0;
              rs        = '0;
              frame_nxt = 1'b0;
              cnt_nxt   = '0;
            end
            ld_row_nxt = lr;
            ld_col_nxt = lc;
            ld_sum_nxt = rs + DW'(in_tdata[0]);
            ps_raddr   = paddr((lr == '0) ? '0 : lr - AW'(1), lc);
            state_nxt  = ST_LD_WR;
          end else if (cnt_r != '0) begin
            cnt_nxt   = cnt_r - CW'(1);
            stk_raddr = SAW'(cnt_r - CW'(1));
            state_nxt = ST_POP;
          end
        end
      end
      ST_LD_WR: begin
        ps_we    = 1'b1;
        ps_waddr = paddr(ld_row_r, ld_col_r);
        ps_wdata = PSUM_W'(ld_sum_r) + ((ld_row_r == '0) ? '0 : ps_q);
        if (DW'(ld_col_r) + DW'(1) >= nc) begin
          lcol_nxt = '0;
          rsum_nxt = '0;
          if (DW'(ld_row_r) + DW'(1) >= nr) begin
            // frame complete: whole bitmap becomes the only region
            lrow_nxt  = '0;
            frame_nxt = 1'b1;
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '{r0: '0, r1: AW'(nr - DW'(1)), c0: '0, c1: AW'(nc - DW'(1))};
            cnt_nxt   = CW'(1);
          end else begin
            lrow_nxt = ld_row_r + AW'(1);
          end
        end else begin
          lrow_nxt = ld_row_r;
          lcol_nxt = ld_col_r + AW'(1);
          rsum_nxt = ld_sum_r;
        end
        state_nxt = ST_IDLE;
      end
      ST_POP: begin
        reg_nxt   = stk_q;
        state_nxt = ST_Q0;
      end
      ST_Q0: begin
        ps_raddr  = paddr(reg_r.r1, reg_r.c1);
        area_nxt  = AREA_W'(DW'(reg_r.r1) - DW'(reg_r.r0) + DW'(1))
                  * AREA_W'(DW'(reg_r.c1) - DW'(reg_r.c0) + DW'(1));
        state_nxt = ST_Q1;
      end
      ST_Q1: begin
        acc_nxt   = ps_q;
        ps_raddr  = paddr(r0m1, reg_r.c1);
        state_nxt = ST_Q2;
      end
      ST_Q2: begin
        acc_nxt   = acc_r - ((reg_r.r0 == '0) ? '0 : ps_q);
        ps_raddr  = paddr(reg_r.r1, c0m1);
        state_nxt = ST_Q3;
      end
      ST_Q3: begin
        acc_nxt   = acc_r - ((reg_r.c0 == '0) ? '0 : ps_q);
        ps_raddr  = paddr(r0m1, c0m1);
        state_nxt = ST_Q4;
      end
      ST_Q4: begin
        acc_nxt   = acc_r + ((reg_r.r0 == '0 || reg_r.c0 == '0) ? '0 : ps_q);
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (CMP_W'(acc_r) == CMP_W'(area_r)) begin
          sym_nxt   = SYM_ONE;
          state_nxt = ST_OUT;
        end else if (acc_r == '0) begin
          sym_nxt   = SYM_ZERO;
          state_nxt = ST_OUT;
        end else begin
          sym_nxt     = SYM_DIV;
          split_r_nxt = (reg_r.r0 != reg_r.r1);
          split_c_nxt = (reg_r.c0 != reg_r.c1);
          idx_nxt     = '0;
          state_nxt   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // a push onto a full stack is dropped
        if (int'(cnt_r) < STACK_DEPTH) begin
          stk_we    = 1'b1;
          stk_waddr = SAW'(cnt_r);
          stk_wdata = push_reg;
          cnt_nxt   = cnt_r + CW'(1);
        end
        if (idx_r == ((split_r_r && split_c_r) ? 2'd3 : 2'd1)) begin
          state_nxt = ST_OUT;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = sym_r;
          out_last_nxt  = (cnt_r == '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // any register write abandons the current frame
    if (cfg_wr_en) begin
      if (cfg_index == CFG_ROWS) rows_nxt = cfg_wdata;
      else cols_nxt = cfg_wdata;
      lrow_nxt  = '0;
      lcol_nxt  = '0;
      rsum_nxt  = '0;
      frame_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

endmodule

@@ sv/qbe_checker.sv @@
// port-level checker for the quadtree bitmap encoder, bound to the top level
// depends on quadtree_bitmap_encoder_top_assert.svh
`include "quadtree_bitmap_encoder_top_assert.svh"

module qbe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [0:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `QBE_ASSERT_NXT(a_rst_clears_out, clk, !rst_n, !out_tvalid, "result valid after reset")
  `QBE_ASSERT_IMP(a_sym_legal, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'd3, "illegal symbol")
  `QBE_ASSERT_IMP(a_load_no_result, clk, rst_n,
    in_tvalid && in_tready && !in_tuser[0] && !out_tvalid, ##1 !out_tvalid,
    "load transfer gave a result")
  `QBE_ASSERT_IMP(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    ##1 (out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled result changed")

endmodule

bind quadtree_bitmap_encoder_top qbe_checker u_qbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ bench/quadtree_bitmap_encoder_scoreboard.sv @@
// result checker for the quadtree bitmap encoder: watches the input, result and register ports,
// keeps its own prefix-sum store and region stack, and compares every result transfer
// depends on qbe_pkg
module quadtree_bitmap_encoder_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [7:0]                    out_tdata,
  input  logic                          out_tlast,
  input  logic                          cfg_wr_en,
  input  logic [qbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qbe_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            fail_count,
  output int                            symbols_pending,
  output int                            regions_left,
  output int                            symbols_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import qbe_pkg::*;

  localparam int DIM   = MAX_DIM_DEF;
  localparam int DEPTH = STACK_DEPTH_DEF;

  typedef struct packed {
    logic [7:0] r0, r1, c0, c1;
  } rect_t;

  typedef struct packed {
    logic [1:0] symbol;
    logic       last;
  } symbol_t;

  logic [PSUM_W-1:0] ones_below [0:DIM*DIM-1];
  rect_t             rect_stack [0:DEPTH-1];
  int                stack_n;
  int                row_ones, pos_row, pos_col;
  bit                frame_done;
  logic [CFG_W-1:0]  rows_reg, cols_reg;
  symbol_t           sym_q [$];
  int                fails, seen;

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic int corner(int r, int c);
    if (r < 0 || c < 0) return 0;
    return int'(ones_below[r*DIM + c]);
  endfunction

  function automatic int rect_ones(rect_t g);
    return corner(g.r1, g.c1) - corner(int'(g.r0) - 1, g.c1)
         - corner(g.r1, int'(g.c0) - 1) + corner(int'(g.r0) - 1, int'(g.c0) - 1);
  endfunction

  task automatic push_rect(int r0, int r1, int c0, int c1);
    if (stack_n < DEPTH) begin
      rect_stack[stack_n] = '{r0[7:0], r1[7:0], c0[7:0], c1[7:0]};
      stack_n++;
    end
  endtask

  task automatic drop_frame();
    row_ones   = 0;
    pos_row    = 0;
    pos_col    = 0;
    frame_done = 0;
    stack_n    = 0;
  endtask

  task automatic take_pixel(logic p);
    int nr, nc, above;
    nr = clamp_dim(rows_reg);
    nc = clamp_dim(cols_reg);
    if (frame_done) drop_frame();
    if (pos_row >= nr || pos_col >= nc) drop_frame();
    row_ones += p;
    above = (pos_row > 0) ? int'(ones_below[(pos_row-1)*DIM + pos_col]) : 0;
    ones_below[pos_row*DIM + pos_col] = PSUM_W'(row_ones + above);
    pos_col++;
    if (pos_col >= nc) begin
      pos_col  = 0;
      row_ones = 0;
      pos_row++;
      if (pos_row >= nr) begin
        pos_row    = 0;
        frame_done = 1;
        stack_n    = 0;
        push_rect(0, nr-1, 0, nc-1);
      end
    end
  endtask

  task automatic pop_symbol();
    rect_t   g;
    int      area, ones, mr, mc;
    symbol_t s;
    if (stack_n == 0) return;
    stack_n--;
    g    = rect_stack[stack_n];
    area = (int'(g.r1) - int'(g.r0) + 1) * (int'(g.c1) - int'(g.c0) + 1);
    ones = rect_ones(g);
    mr   = (int'(g.r0) + int'(g.r1)) / 2;
    mc   = (int'(g.c0) + int'(g.c1)) / 2;
    if (ones == area) begin
      s.symbol = SYM_ONE;
    end else if (ones == 0) begin
      s.symbol = SYM_ZERO;
    end else begin
      s.symbol = SYM_DIV;
      // pushed in reverse so the first part comes off the stack first
      if (g.r0 == g.r1) begin
        push_rect(g.r0, g.r1, mc+1, g.c1);
        push_rect(g.r0, g.r1, g.c0, mc);
      end else if (g.c0 == g.c1) begin
        push_rect(mr+1, g.r1, g.c0, g.c1);
        push_rect(g.r0, mr, g.c0, g.c1);
      end else begin
        push_rect(mr+1, g.r1, mc+1, g.c1);
        push_rect(mr+1, g.r1, g.c0, mc);
        push_rect(g.r0, mr, mc+1, g.c1);
        push_rect(g.r0, mr, g.c0, mc);
      end
    end
    s.last = (stack_n == 0);
    sym_q.push_back(s);
  endtask

  always @(posedge clk) begin
    symbol_t want;
    if (!rst_n) begin
      rows_reg = 1;
      cols_reg = 1;
      drop_frame();
      sym_q.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen++;
        if (sym_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected symbol %0d last %0b", $realtime, out_tdata[1:0], out_tlast);
        end else begin
          want = sym_q.pop_front();
          if (want.symbol !== out_tdata[1:0] || want.last !== out_tlast) begin
            fails++;
            if (fails <= 10)
              $display("%0t: symbol mismatch, expected %0d last %0b, got %0d last %0b",
                       $realtime, want.symbol, want.last, out_tdata[1:0], out_tlast);
          end
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ROWS) rows_reg = cfg_wdata;
        else cols_reg = cfg_wdata;
        drop_frame();
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == KIND_LOAD) take_pixel(in_tdata[0]);
        else pop_symbol();
      end
    end
    fail_count      <= fails;
    symbols_pending <= sym_q.size();
    regions_left    <= stack_n;
    symbols_seen    <= seen;
  end

endmodule

@@ bench/quadtree_bitmap_encoder_top_test.sv @@
// stimulus and verdict for the quadtree bitmap encoder
// depends on qbe_pkg, quadtree_bitmap_encoder_top and quadtree_bitmap_encoder_scoreboard
module quadtree_bitmap_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qbe_pkg::*;

  localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 20;    // longest step plus margin

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_tvalid = 0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;   // [0] pixel
  logic [0:0]           in_tuser = '0;   // [0] kind
  logic                 out_tvalid;
  logic                 out_tready = 0;
  logic [7:0]           out_tdata;      // [1:0] symbol
  logic                 out_tlast;
  logic                 cfg_wr_en = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count, symbols_pending, regions_left, symbols_seen;
  int burst_left, items_sent, frames_loaded, idle_cycles;

  always #10 clk = ~clk;

  quadtree_bitmap_encoder_top dut (.*);

  quadtree_bitmap_encoder_scoreboard checker_i (.*);

  // watchdog: any cycle without a transfer counts towards the limit
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: switches at random among four modes, from always ready to long stalls
  int rx_mode, rx_hold, rx_age;
  always @(posedge clk) begin
    if (rx_age == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_age  = $urandom_range(100, 400);
    end
    rx_age--;
    if (rx_hold > 0) begin
      rx_hold--;
    end else begin
      case (rx_mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_tready <= ~out_tready;
          rx_hold = out_tready ? $urandom_range(0, 12) : $urandom_range(0, 3);
        end
        default: begin
          out_tready <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // one input transfer; the sender works in bursts with random gaps between them
  task automatic send(logic kind, logic pix);
    if (burst_left == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, pix};
    items_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and wait until every expected symbol has arrived
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (symbols_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register writes only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  function automatic int eff_dim(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  // pixel content styles: noise, solid ones, solid zeros, checker blocks, sparse
  function automatic logic pick_pixel(int style, int r, int c, int blk);
    case (style)
      0: return 1'($urandom_range(0, 1));
      1: return 1'b1;
      2: return 1'b0;
      3: return 1'(((r >> blk) ^ (c >> blk)) & 1);
      default: return ($urandom_range(0, 15) == 0);
    endcase
  endfunction

  // load a frame, optionally stopping early; returns without stepping
  task automatic load_frame(int nr, int nc, int style, int stop_at);
    int blk, n;
    blk = $urandom_range(0, 3);
    n   = 0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (n == stop_at) return;
        send(KIND_LOAD, pick_pixel(style, r, c, blk));
        n++;
      end
    end
    frames_loaded++;
  endtask

  // step until the stack is empty; the count seen lags one transfer, so one extra step may go
  task automatic encode_all();
    do send(KIND_STEP, 1'($urandom_range(0, 1))); while (regions_left != 0);
  endtask

  task automatic run_frame(logic [CFG_W-1:0] rv, logic [CFG_W-1:0] cv, int style);
    drain();
    write_reg(CFG_ROWS, rv);
    write_reg(CFG_COLS, cv);
    load_frame(eff_dim(rv), eff_dim(cv), style, -1);
    encode_all();
  endtask

  initial begin
    logic [CFG_W-1:0] rv, cv;
    int nr, nc, style;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: steps with no frame, a single pixel of each value, steps after the final symbol
    send(KIND_STEP, 1'b0);
    send(KIND_STEP, 1'b1);
    send(KIND_LOAD, 1'b1);
    send(KIND_STEP, 1'b0);
    send(KIND_STEP, 1'b0);
    send(KIND_LOAD, 1'b0);
    send(KIND_STEP, 1'b1);
    // 2x2 mixed frame: divide into four single pixels
    drain();
    write_reg(CFG_ROWS, 9'd2);
    write_reg(CFG_COLS, 9'd2);
    send(KIND_LOAD, 1'b1);
    send(KIND_STEP, 1'b1);  // step in the middle of a load
    send(KIND_LOAD, 1'b0);
    send(KIND_LOAD, 1'b0);
    send(KIND_LOAD, 1'b1);
    encode_all();
    // pixel after an encoded frame starts a new frame
    send(KIND_LOAD, 1'b1);
    send(KIND_LOAD, 1'b1);
    send(KIND_LOAD, 1'b1);
    send(KIND_LOAD, 1'b1);
    send(KIND_STEP, 1'b0);
    // out-of-range register values clamp
    drain();
    run_frame(9'd0, 9'd3, 0);      // one row splits by columns
    run_frame(9'd5, 9'd0, 0);      // one column splits by rows
    run_frame(9'd511, 9'd1, 1);    // above the limit acts as the limit

    // random frames, mostly small
    while (items_sent < 600) begin
      case ($urandom_range(0, 19))
        0: begin
          rv = 9'd0;
          cv = 9'($urandom_range(1, 3));
        end
        1: begin
          rv = 9'd16;
          cv = 9'd4;
        end
        default: begin
          rv = 9'($urandom_range(1, 9));
          cv = 9'($urandom_range(1, 9));
        end
      endcase
      nr    = eff_dim(rv);
      nc    = eff_dim(cv);
      style = $urandom_range(0, 4);
      drain();
      write_reg(CFG_ROWS, rv);
      write_reg(CFG_COLS, cv);
      case ($urandom_range(0, 9))
        0: begin
          // abandoned by a register write part way through loading
          load_frame(nr, nc, style, $urandom_range(0, nr*nc - 1));
        end
        1: begin
          // encoding cut short by the next frame
          load_frame(nr, nc, style, -1);
          repeat ($urandom_range(0, 3)) send(KIND_STEP, 1'b0);
          load_frame(nr, nc, $urandom_range(0, 4), -1);
          encode_all();
        end
        2: begin
          // a few stray steps before the frame
          repeat ($urandom_range(1, 3)) send(KIND_STEP, 1'b1);
          load_frame(nr, nc, style, -1);
          encode_all();
        end
        default: begin
          load_frame(nr, nc, style, -1);
          encode_all();
        end
      endcase
    end

    drain();
    $display("%0d input transfers, %0d frames loaded, %0d symbols checked",
             items_sent, frames_loaded, symbols_seen);
    if (fail_count == 0 && symbols_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ quadtree_bitmap_encoder_top.f @@
+incdir+sv
sv/qbe_pkg.sv
sv/quadtree_bitmap_encoder_top.sv
sv/qbe_checker.sv
bench/quadtree_bitmap_encoder_scoreboard.sv
bench/quadtree_bitmap_encoder_top_test.sv
